// ===== design/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window maximum block
// Control group sent from the sequencer to every cell of the candidate row.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

	// Width of the window_width configuration register.
	localparam int CFG_W = 7;

	// Per-cycle command to the row of candidate cells.
	typedef struct packed {
		logic step;   // a request is consumed this cycle
		logic drop;   // oldest candidate leaves the window on this step
		logic clear;  // the request ends its sequence: empty the row
		logic purge;  // shift out one stale head after a width decrease
	} swm_ctrl_t;

endpackage

`default_nettype wire

// ===== design/swm_ifs.sv =====
// ----------------------------------------------------------------------------
// swm interfaces: sample, result and configuration channels
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface swm_in_if #(
	parameter int SAMPLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swm_out_if #(
	parameter int SAMPLE_BITS = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] window_max;
	logic                          last_result;

	modport source (output valid, output window_max, output last_result, input ready);
	modport sink   (input valid, input window_max, input last_result, output ready);
endinterface

interface swm_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] window_width;

	modport source (output valid, output window_width, input ready);
	modport sink   (input valid, input window_width, output ready);
endinterface

`default_nettype wire

// ===== design/sliding_window_max_top.sv =====
// A result appears in the output register in the cycle after its request.
// Throughput: one request per cycle while the output slot is free and no stale
// head waits. After a width decrease, stale head candidates are shifted out one
// at a time before the next request is taken.
// Reset: asynchronous, active low; row emptied, fill count zero, window width 1.
// ----------------------------------------------------------------------------
// sliding_window_max_top: running maximum over the last W samples
// A row of WINDOW_MAX cells holds a strictly decreasing candidate run, oldest
// at cell 0. Each request ages the run, drops at most one head, pops
// candidates not above the new sample and appends it.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_max_top
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  wire      clk,
	input  wire      arst_n,
	swm_in_if.sink   samples,
	swm_out_if.source results,
	swm_cfg_if.sink  cfg
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);

	swm_ctrl_t ctrl;
	logic      produce;
	logic      slot_free;
	logic [CNT_W-1:0] width;

	// neighbor chain, padded with an empty slot beyond the last cell
	logic                          c_valid [0:WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] c_value [0:WINDOW_MAX];
	logic        [CNT_W-1:0]       c_age   [0:WINDOW_MAX];
	logic                          c_gt    [0:WINDOW_MAX];
	logic                          c_keep  [0:WINDOW_MAX];
	logic [WINDOW_MAX-1:0]         vbits;

	// output register
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] window_max_q;
	logic                          last_result_q;

	assign slot_free = !out_valid_q || results.ready;

	swm_ctrl #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.window_width),
		.cfg_ready (cfg.ready),
		.in_valid  (samples.valid),
		.in_last   (samples.last_sample),
		.slot_free (slot_free),
		.head_valid(c_valid[0]),
		.head_age  (c_age[0]),
		.in_ready  (samples.ready),
		.produce   (produce),
		.width     (width),
		.ctrl      (ctrl)
	);

	// cell 0 always sees a "kept" left side: an empty head takes the sample
	assign c_keep[0]           = 1'b1;
	assign c_valid[WINDOW_MAX] = 1'b0;
	assign c_value[WINDOW_MAX] = '0;
	assign c_age[WINDOW_MAX]   = '0;
	assign c_gt[WINDOW_MAX]    = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
			swm_cell #(
				.SAMPLE_BITS(SAMPLE_BITS),
				.AGE_W      (CNT_W)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.sample   (samples.sample),
				.nxt_valid(c_valid[gi+1]),
				.nxt_value(c_value[gi+1]),
				.nxt_age  (c_age[gi+1]),
				.nxt_gt   (c_gt[gi+1]),
				.prv_keep (c_keep[gi]),
				.valid    (c_valid[gi]),
				.value    (c_value[gi]),
				.age      (c_age[gi]),
				.gt       (c_gt[gi]),
				.keep     (c_keep[gi+1])
			);
			assign vbits[gi] = c_valid[gi];
		end
	endgenerate

	// c_keep[1] is cell 0's keep: the new head is either the surviving oldest
	// candidate or, if everything was dropped or popped, the sample itself.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.step) begin
			out_valid_q <= produce;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			if (c_keep[1]) begin
				window_max_q <= ctrl.drop ? c_value[1] : c_value[0];
			end else begin
				window_max_q <= samples.sample;
			end
			last_result_q <= samples.last_sample;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.window_max  = window_max_q;
	assign results.last_result = last_result_q;

	// candidate run is always a contiguous prefix of the row
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(vbits & (vbits + 1'b1)) == '0)
		else $error("candidate row is not a contiguous prefix");

	// a request is only taken once the head lies inside the window
	a_head_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |-> (!c_valid[0] || c_age[0] < width))
		else $error("request taken with a stale head candidate");

	// end of sequence empties the row
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> !c_valid[0])
		else $error("row not empty after last sample");

	// a producing request shows up in the output register next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		produce |=> results.valid)
		else $error("result lost after producing request");

	// the row is never empty right after a request that does not end a sequence
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step && !ctrl.clear |=> c_valid[0])
		else $error("row empty after a sample was appended");

endmodule

`default_nettype wire

// ===== design/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell: one slot of the monotonic candidate row
// Holds a candidate value and its age; loads from its right-hand neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell
	import swm_pkg::*;
#(
	parameter int SAMPLE_BITS = 32,
	parameter int AGE_W       = 7
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  swm_ctrl_t                    ctrl,
	input  wire signed [SAMPLE_BITS-1:0] sample,
	// right-hand neighbor (next newer candidate)
	input  wire                          nxt_valid,
	input  wire signed [SAMPLE_BITS-1:0] nxt_value,
	input  wire        [AGE_W-1:0]       nxt_age,
	input  wire                          nxt_gt,
	// left-hand neighbor keeps its candidate after this step
	input  wire                          prv_keep,
	output logic                         valid,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic       [AGE_W-1:0]       age,
	output logic                         gt,
	output logic                         keep
);

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic        [AGE_W-1:0]       age_q;

	// candidate beats the incoming sample, so it survives the pop
	assign gt    = valid_q && (value_q > sample);
	assign keep  = ctrl.drop ? nxt_gt : gt;
	assign valid = valid_q;
	assign value = value_q;
	assign age   = age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.step && ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.step) begin
			valid_q <= keep || prv_keep;
		end else if (ctrl.purge) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (keep) begin
				value_q <= ctrl.drop ? nxt_value : value_q;
				age_q   <= (ctrl.drop ? nxt_age : age_q) + 1'b1;
			end else begin
				// first free slot after the kept run takes the new sample
				value_q <= sample;
				age_q   <= '0;
			end
		end else if (ctrl.purge) begin
			value_q <= nxt_value;
			age_q   <= nxt_age;
		end
	end

endmodule

`default_nettype wire

// ===== design/swm_ctrl.sv =====
// ----------------------------------------------------------------------------
// swm_ctrl: window width register, fill counter and row sequencing
// Decides head drop, stale-head purge and whether a request yields a result.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_ctrl
	import swm_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	input  wire [CFG_W-1:0]                     cfg_data,
	output logic                                cfg_ready,
	input  wire                                 in_valid,
	input  wire                                 in_last,
	input  wire                                 slot_free,
	input  wire                                 head_valid,
	input  wire [$clog2(WINDOW_MAX+1)-1:0]      head_age,
	output logic                                in_ready,
	output logic                                produce,
	output logic [$clog2(WINDOW_MAX+1)-1:0]     width,
	output swm_ctrl_t                           ctrl
);

	localparam int CNT_W = $clog2(WINDOW_MAX + 1);
	localparam int EW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CFG_W-1:0] width_q;
	logic [CNT_W-1:0] seen_q;
	logic [EW-1:0]    wext;
	logic [CNT_W-1:0] seen_clamp;
	logic [CNT_W-1:0] seen_new;
	logic             stale;
	logic             take;

	assign cfg_ready = 1'b1;

	always_comb begin
		wext = EW'(width_q);
		if (wext == '0) begin
			width = CNT_W'(1);
		end else if (wext > EW'(WINDOW_MAX)) begin
			width = CNT_W'(WINDOW_MAX);
		end else begin
			width = CNT_W'(wext);
		end
	end

	// a narrower window can leave heads older than the window
	assign stale    = head_valid && (head_age >= width);
	assign in_ready = !stale && slot_free;
	assign take     = in_valid && in_ready;

	assign seen_clamp = (seen_q > width) ? width : seen_q;
	assign seen_new   = (seen_clamp < width) ? seen_clamp + 1'b1 : seen_clamp;
	assign produce    = take && (seen_new >= width);

	// stale heads leave only once a request waits: a width raised again
	// before the next request still sees them
	always_comb begin
		ctrl.step  = take;
		ctrl.drop  = head_valid && ({1'b0, head_age} + 1'b1 >= {1'b0, width});
		ctrl.clear = take && in_last;
		ctrl.purge = stale && in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(1);
			seen_q  <= '0;
		end else begin
			if (cfg_valid) begin
				width_q <= cfg_data;
			end
			if (take) begin
				seen_q <= in_last ? '0 : seen_new;
			end
		end
	end

endmodule

`default_nettype wire
